@@ hw/rtl/kscb_pkg.sv @@
`default_nettype none
package kscb_pkg;

	// field and register widths
	localparam int COUNT_WIDTH = 16;
	localparam int BIN_W       = 18;
	localparam int REG_W       = 16;
	localparam int IDX_W       = 4;

	// internal datapath widths
	localparam int D_W      = 18;              // d = k - 1
	localparam int DV_W     = 22;              // 9 * d
	localparam int Q_W      = 30;              // q = 2^33 / (9d), Q0.32
	localparam int RCP_STEPS = 34;             // dividend 2^33 has 34 bits
	localparam int S_W      = 15;              // s = sqrt(q), Q0.16
	localparam int SQ_STEPS = Q_W / 2;
	localparam int SR_W     = 17;              // root remainder
	localparam int SZ_W     = S_W + REG_W;     // s * z
	localparam int QSH_W    = Q_W - 8;         // q >> 8
	localparam int X_W      = 28;              // x, Q4.24
	localparam int X2_W     = 2 * X_W;
	localparam int X3_W     = 3 * X_W;
	localparam int PP_W     = X_W + D_W;       // partial product of x^3 and d
	localparam int W_W      = X3_W + D_W;      // d * x^3
	localparam int FRAC_W   = 57;
	localparam int TOP_W    = W_W - FRAC_W;    // quotient steps
	localparam int N_W      = TOP_W + 1;

	localparam logic [X_W-1:0] ONE_Q24 = X_W'(1) << 24;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MIN   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_MAX   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_ERR   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_QUANT = IDX_W'(3);

	// clamp kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_MIN  = 2'd1;
	localparam logic [1:0] KIND_MAX  = 2'd2;

endpackage
`default_nettype wire

@@ hw/rtl/kscb_recip.sv @@
`default_nettype none
// q = floor(2^33 / (9d)), restoring division, one quotient bit per stage
module kscb_recip (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        in_valid,
	input  wire logic                        in_few,
	input  wire logic [kscb_pkg::D_W-1:0]    in_d,
	input  wire logic [kscb_pkg::DV_W-1:0]   in_dv,
	output logic                             out_valid,
	output logic                             out_few,
	output logic [kscb_pkg::D_W-1:0]         out_d,
	output logic [kscb_pkg::Q_W-1:0]         out_q
);
	import kscb_pkg::*;

	typedef struct packed {
		logic            few;
		logic [D_W-1:0]  d;
		logic [DV_W-1:0] dv;
		logic [DV_W-1:0] rem;
		logic [Q_W-1:0]  quo;
	} rcp_t;

	logic vld_s [RCP_STEPS];
	rcp_t rcp_s [RCP_STEPS];

	for (genvar i = 0; i < RCP_STEPS; i++) begin : g_step
		localparam logic DIVIDEND_BIT = (i == 0) ? 1'b1 : 1'b0;
		logic          prev_v;
		rcp_t          prev;
		rcp_t          nxt;
		logic [DV_W:0] shifted;

		if (i == 0) begin : g_first
			assign prev_v = in_valid;
			assign prev   = '{few: in_few, d: in_d, dv: in_dv, rem: '0, quo: '0};
		end else begin : g_next
			assign prev_v = vld_s[i-1];
			assign prev   = rcp_s[i-1];
		end

		// trial subtract
		always_comb begin
			nxt     = prev;
			shifted = {prev.rem, DIVIDEND_BIT};
			if (shifted >= {1'b0, prev.dv}) begin
				nxt.rem = DV_W'(shifted - {1'b0, prev.dv});
				nxt.quo = {prev.quo[Q_W-2:0], 1'b1};
			end else begin
				nxt.rem = shifted[DV_W-1:0];
				nxt.quo = {prev.quo[Q_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rcp_s[i] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[RCP_STEPS-1];
	assign out_few   = rcp_s[RCP_STEPS-1].few;
	assign out_d     = rcp_s[RCP_STEPS-1].d;
	assign out_q     = rcp_s[RCP_STEPS-1].quo;

endmodule
`default_nettype wire

@@ hw/rtl/kscb_sqrt.sv @@
`default_nettype none
// s = floor(sqrt(q)), digit by digit, one root bit per stage
module kscb_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire logic                      in_valid,
	input  wire logic                      in_few,
	input  wire logic [kscb_pkg::D_W-1:0]  in_d,
	input  wire logic [kscb_pkg::Q_W-1:0]  in_q,
	output logic                           out_valid,
	output logic                           out_few,
	output logic [kscb_pkg::D_W-1:0]       out_d,
	output logic [kscb_pkg::Q_W-1:0]       out_q,
	output logic [kscb_pkg::S_W-1:0]       out_s
);
	import kscb_pkg::*;

	typedef struct packed {
		logic            few;
		logic [D_W-1:0]  d;
		logic [Q_W-1:0]  q;
		logic [SR_W-1:0] rem;
		logic [S_W-1:0]  root;
	} sq_t;

	logic vld_s [SQ_STEPS];
	sq_t  sq_s  [SQ_STEPS];

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
		logic            prev_v;
		sq_t             prev;
		sq_t             nxt;
		logic [SR_W+1:0] shifted;
		logic [SR_W+1:0] trial;

		if (i == 0) begin : g_first
			assign prev_v = in_valid;
			assign prev   = '{few: in_few, d: in_d, q: in_q, rem: '0, root: '0};
		end else begin : g_next
			assign prev_v = vld_s[i-1];
			assign prev   = sq_s[i-1];
		end

		// bring in two bits, try root*4+1
		always_comb begin
			nxt     = prev;
			shifted = {prev.rem, prev.q[Q_W-1-2*i -: 2]};
			trial   = (SR_W+2)'({prev.root, 2'b01});
			if (shifted >= trial) begin
				nxt.rem  = SR_W'(shifted - trial);
				nxt.root = {prev.root[S_W-2:0], 1'b1};
			end else begin
				nxt.rem  = shifted[SR_W-1:0];
				nxt.root = {prev.root[S_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[i] <= nxt;
			end
		end
	end

	assign out_valid = vld_s[SQ_STEPS-1];
	assign out_few   = sq_s[SQ_STEPS-1].few;
	assign out_d     = sq_s[SQ_STEPS-1].d;
	assign out_q     = sq_s[SQ_STEPS-1].q;
	assign out_s     = sq_s[SQ_STEPS-1].root;

endmodule
`default_nettype wire

@@ hw/rtl/kscb_cube.sv @@
`default_nettype none
// x = 1 - q + s*z, then d * x^3 through split multiplies
module kscb_cube (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic [kscb_pkg::REG_W-1:0]  quantile,
	input  wire logic                        in_valid,
	input  wire logic                        in_few,
	input  wire logic [kscb_pkg::D_W-1:0]    in_d,
	input  wire logic [kscb_pkg::Q_W-1:0]    in_q,
	input  wire logic [kscb_pkg::S_W-1:0]    in_s,
	output logic                             out_valid,
	output logic                             out_few,
	output logic [kscb_pkg::TOP_W-1:0]       out_top,
	output logic                             out_frac
);
	import kscb_pkg::*;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic              few_s1, few_s2, few_s3, few_s4, few_s5, few_s6, few_s7;
	logic [D_W-1:0]    d_s1, d_s2, d_s3, d_s4, d_s5;
	logic [SZ_W-1:0]   sz_s1;
	logic [QSH_W-1:0]  qsh_s1;
	logic [X_W-1:0]    x_s2, x_s3;
	logic [X2_W-1:0]   x2_s3;
	logic [X2_W-1:0]   ph_s4, pl_s4;
	logic [X3_W-1:0]   x3_s5;
	logic [PP_W-1:0]   m0_s6, m1_s6, m2_s6;
	logic [W_W-1:0]    w_sum;
	logic [TOP_W-1:0]  top_s7;
	logic              frac_s7;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// full d * x^3 from three partial products
	assign w_sum = (W_W'(m2_s6) << (2 * X_W)) + (W_W'(m1_s6) << X_W) + W_W'(m0_s6);

	always_ff @(posedge clk) begin
		if (adv) begin
			// s * z
			few_s1 <= in_few;
			d_s1   <= in_d;
			sz_s1  <= SZ_W'(in_s) * SZ_W'(quantile);
			qsh_s1 <= in_q[Q_W-1:8];
			// x in Q4.24
			few_s2 <= few_s1;
			d_s2   <= d_s1;
			x_s2   <= ONE_Q24 - X_W'(qsh_s1) + X_W'(sz_s1[SZ_W-1:4]);
			// x^2
			few_s3 <= few_s2;
			d_s3   <= d_s2;
			x_s3   <= x_s2;
			x2_s3  <= X2_W'(x_s2) * X2_W'(x_s2);
			// x^2 halves times x
			few_s4 <= few_s3;
			d_s4   <= d_s3;
			ph_s4  <= X2_W'(x2_s3[X2_W-1:X_W]) * X2_W'(x_s3);
			pl_s4  <= X2_W'(x2_s3[X_W-1:0]) * X2_W'(x_s3);
			// x^3
			few_s5 <= few_s4;
			d_s5   <= d_s4;
			x3_s5  <= (X3_W'(ph_s4) << X_W) + X3_W'(pl_s4);
			// x^3 thirds times d
			few_s6 <= few_s5;
			m0_s6  <= PP_W'(x3_s5[X_W-1:0]) * PP_W'(d_s5);
			m1_s6  <= PP_W'(x3_s5[2*X_W-1:X_W]) * PP_W'(d_s5);
			m2_s6  <= PP_W'(x3_s5[X3_W-1:2*X_W]) * PP_W'(d_s5);
			// split into integer part and fraction flag
			few_s7  <= few_s6;
			top_s7  <= w_sum[W_W-1:FRAC_W];
			frac_s7 <= |w_sum[FRAC_W-1:0];
		end
	end

	assign out_valid = vld_s7;
	assign out_few   = few_s7;
	assign out_top   = top_s7;
	assign out_frac  = frac_s7;

endmodule
`default_nettype wire

@@ hw/rtl/kscb_div.sv @@
`default_nettype none
// n = ceil(top / eps) bit by bit, then clamp into the output register
module kscb_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic [kscb_pkg::REG_W-1:0]  bound_err,
	input  wire logic [kscb_pkg::REG_W-1:0]  min_cnt,
	input  wire logic [kscb_pkg::REG_W-1:0]  max_cnt,
	input  wire logic                        in_valid,
	input  wire logic                        in_few,
	input  wire logic [kscb_pkg::TOP_W-1:0]  in_top,
	input  wire logic                        in_frac,
	output logic                             out_valid,
	output logic [kscb_pkg::COUNT_WIDTH-1:0] out_limit,
	output logic [1:0]                       out_kind
);
	import kscb_pkg::*;

	typedef struct packed {
		logic             few;
		logic             frac;
		logic [TOP_W-1:0] top;
		logic [REG_W-1:0] rem;
		logic [TOP_W-1:0] quo;
	} dv_t;

	logic dvld_s [TOP_W];
	dv_t  dv_s   [TOP_W];

	for (genvar i = 0; i < TOP_W; i++) begin : g_step
		logic           prev_v;
		dv_t            prev;
		dv_t            nxt;
		logic [REG_W:0] shifted;

		if (i == 0) begin : g_first
			assign prev_v = in_valid;
			assign prev   = '{few: in_few, frac: in_frac, top: in_top, rem: '0, quo: '0};
		end else begin : g_next
			assign prev_v = dvld_s[i-1];
			assign prev   = dv_s[i-1];
		end

		// trial subtract of eps
		always_comb begin
			nxt     = prev;
			shifted = {prev.rem, prev.top[TOP_W-1-i]};
			if (shifted >= {1'b0, bound_err}) begin
				nxt.rem = REG_W'(shifted - {1'b0, bound_err});
				nxt.quo = {prev.quo[TOP_W-2:0], 1'b1};
			end else begin
				nxt.rem = shifted[REG_W-1:0];
				nxt.quo = {prev.quo[TOP_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[i] <= 1'b0;
			end else if (adv) begin
				dvld_s[i] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[i] <= nxt;
			end
		end
	end

	logic                   nvld_s1;
	logic                   ovld_s2;
	logic                   few_s1;
	logic [N_W-1:0]         n_s1;
	logic [COUNT_WIDTH-1:0] limit_s2;
	logic [1:0]             kind_s2;
	logic [COUNT_WIDTH-1:0] limit_nxt;
	logic [1:0]             kind_nxt;
	dv_t                    last;

	assign last = dv_s[TOP_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvld_s1 <= 1'b0;
			ovld_s2 <= 1'b0;
		end else if (adv) begin
			nvld_s1 <= dvld_s[TOP_W-1];
			ovld_s2 <= nvld_s1;
		end
	end

	// clamp: too few bins or zero error give max, then minimum tested before maximum
	always_comb begin
		limit_nxt = n_s1[COUNT_WIDTH-1:0];
		kind_nxt  = KIND_NONE;
		if (few_s1) begin
			limit_nxt = max_cnt;
		end else if (bound_err == '0) begin
			limit_nxt = max_cnt;
			kind_nxt  = KIND_MAX;
		end else if (n_s1 < N_W'(min_cnt)) begin
			limit_nxt = min_cnt;
			kind_nxt  = KIND_MIN;
		end else if (n_s1 > N_W'(max_cnt)) begin
			limit_nxt = max_cnt;
			kind_nxt  = KIND_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// round up on any remainder or fraction
			few_s1   <= last.few;
			n_s1     <= N_W'(last.quo) + N_W'((last.rem != '0) || last.frac);
			limit_s2 <= limit_nxt;
			kind_s2  <= kind_nxt;
		end
	end

	assign out_valid = ovld_s2;
	assign out_limit = limit_s2;
	assign out_kind  = kind_s2;

endmodule
`default_nettype wire

@@ hw/rtl/kld_sample_count_bound.sv @@
`default_nettype none
// KLD-sampling particle count bound.
// Input channel: bin_count (occupied bins k) with in_valid / in_ready.
// Output channel: particle_limit and clamp_kind with out_valid / out_ready.
// Config: cfg_we, cfg_index, cfg_data write min_particles (0), max_particles
// (1), bound_error (2), normal_quantile (3); other indexes are ignored.
// The user must write registers only while no transfer is in flight;
// the block itself does not enforce this. Throughput: one item per
// cycle while the receiver does not stall. Stages from input transfer
// to result valid: one input stage, 34 reciprocal divider steps, 15
// square root steps, 7 stages of multiplies for d*x^3, 45 steps of the
// final divider, one rounding stage and the clamp stage (output register).
// Reset clears all valid bits and loads the register defaults
// (100, 5000, 655, 12288); the block takes items right after reset.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; bubbles still advance while the output is empty.
module kld_sample_count_bound (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [kscb_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [kscb_pkg::REG_W-1:0]       cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [kscb_pkg::BIN_W-1:0]       bin_count,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [kscb_pkg::COUNT_WIDTH-1:0]      particle_limit,
	output logic [1:0]                            clamp_kind
);
	import kscb_pkg::*;

	logic [REG_W-1:0] min_q, max_q, err_q, quant_q;
	logic             adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= REG_W'(100);
			max_q   <= REG_W'(5000);
			err_q   <= REG_W'(655);
			quant_q <= REG_W'(12288);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN:   min_q   <= cfg_data;
				REG_MAX:   max_q   <= cfg_data;
				REG_ERR:   err_q   <= cfg_data;
				REG_QUANT: quant_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances unless a result waits on a stalled receiver
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// input stage: d = k - 1 and 9d
	logic            vld_s1, few_s1;
	logic [D_W-1:0]  d_s1;
	logic [DV_W-1:0] dv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			few_s1 <= (bin_count <= BIN_W'(1));
			d_s1   <= D_W'(bin_count - BIN_W'(1));
			dv_s1  <= (DV_W'(D_W'(bin_count - BIN_W'(1))) << 3) +
			          DV_W'(D_W'(bin_count - BIN_W'(1)));
		end
	end

	logic             rc_valid, rc_few;
	logic [D_W-1:0]   rc_d;
	logic [Q_W-1:0]   rc_q;

	kscb_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (vld_s1),
		.in_few    (few_s1),
		.in_d      (d_s1),
		.in_dv     (dv_s1),
		.out_valid (rc_valid),
		.out_few   (rc_few),
		.out_d     (rc_d),
		.out_q     (rc_q)
	);

	logic             sq_valid, sq_few;
	logic [D_W-1:0]   sq_d;
	logic [Q_W-1:0]   sq_q;
	logic [S_W-1:0]   sq_s;

	kscb_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (rc_valid),
		.in_few    (rc_few),
		.in_d      (rc_d),
		.in_q      (rc_q),
		.out_valid (sq_valid),
		.out_few   (sq_few),
		.out_d     (sq_d),
		.out_q     (sq_q),
		.out_s     (sq_s)
	);

	logic             cb_valid, cb_few, cb_frac;
	logic [TOP_W-1:0] cb_top;

	kscb_cube u_cube (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.quantile  (quant_q),
		.in_valid  (sq_valid),
		.in_few    (sq_few),
		.in_d      (sq_d),
		.in_q      (sq_q),
		.in_s      (sq_s),
		.out_valid (cb_valid),
		.out_few   (cb_few),
		.out_top   (cb_top),
		.out_frac  (cb_frac)
	);

	kscb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.bound_err (err_q),
		.min_cnt   (min_q),
		.max_cnt   (max_q),
		.in_valid  (cb_valid),
		.in_few    (cb_few),
		.in_top    (cb_top),
		.in_frac   (cb_frac),
		.out_valid (out_valid),
		.out_limit (particle_limit),
		.out_kind  (clamp_kind)
	);

endmodule
`default_nettype wire
